/* rtl/spg_pkg.sv */
// ----------------------------------------------------------------------------
// spg_pkg
// shared types, register codes and arithmetic helpers of the spiral generator
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int RAD_STEPS   = 14;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int MAX_STEPS   = 24;
    localparam logic signed [30:0] CORDIC_GAIN = 31'sd652032874;

    typedef enum logic [2:0] {
        REG_POINT_TOTAL  = 3'd0,
        REG_TURN_COUNT   = 3'd1,
        REG_OUTER_RADIUS = 3'd2,
        REG_INNER_RADIUS = 3'd3,
        REG_CENTER_COL   = 3'd4,
        REG_CENTER_ROW   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        beyond;
        logic        fin;
        logic        sgn;
        logic [29:0] rad_num;
        logic [23:0] turn_prod;
        logic [15:0] phase;
    } t_item;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [16:0] div_step(input logic [15:0] rem, input logic nbit,
                                             input logic [15:0] den);
        logic [16:0] sh;
        logic [16:0] df;
        sh = {rem, nbit};
        df = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            div_step = {1'b1, df[15:0]};
        end else begin
            div_step = {1'b0, sh[15:0]};
        end
    endfunction

    // arctangent of 2^-k in turns scaled by 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        case (k)
            5'd0:    atan_turn = 32'd536870912;
            5'd1:    atan_turn = 32'd316933406;
            5'd2:    atan_turn = 32'd167458907;
            5'd3:    atan_turn = 32'd85004756;
            5'd4:    atan_turn = 32'd42667331;
            5'd5:    atan_turn = 32'd21354465;
            5'd6:    atan_turn = 32'd10679838;
            5'd7:    atan_turn = 32'd5340245;
            5'd8:    atan_turn = 32'd2670163;
            5'd9:    atan_turn = 32'd1335087;
            5'd10:   atan_turn = 32'd667544;
            5'd11:   atan_turn = 32'd333772;
            5'd12:   atan_turn = 32'd166886;
            5'd13:   atan_turn = 32'd83443;
            5'd14:   atan_turn = 32'd41722;
            5'd15:   atan_turn = 32'd20861;
            5'd16:   atan_turn = 32'd10430;
            5'd17:   atan_turn = 32'd5215;
            5'd18:   atan_turn = 32'd2608;
            5'd19:   atan_turn = 32'd1304;
            5'd20:   atan_turn = 32'd652;
            5'd21:   atan_turn = 32'd326;
            5'd22:   atan_turn = 32'd163;
            5'd23:   atan_turn = 32'd81;
            default: atan_turn = 32'd0;
        endcase
    endfunction

endpackage

/* rtl/spg_front.sv */
// ----------------------------------------------------------------------------
// spg_front
// classifies an incoming word and forms the dividends for the back end
// ----------------------------------------------------------------------------
module spg_front
    import spg_pkg::*;
(
    input  logic [15:0] i_point_total,
    input  logic [7:0]  i_turn_count,
    input  logic [13:0] i_outer_radius,
    input  logic [13:0] i_inner_radius,
    input  logic [15:0] i_point_index,
    input  logic [15:0] i_phase_offset,
    input  logic        i_final_point,
    output t_item       o_item
);

    logic        sgn;
    logic [13:0] mag;

    always_comb begin
        sgn = i_inner_radius > i_outer_radius;
        mag = sgn ? (i_inner_radius - i_outer_radius) : (i_outer_radius - i_inner_radius);
        o_item.beyond    = i_point_index >= i_point_total;
        o_item.fin       = i_final_point;
        o_item.sgn       = sgn;
        o_item.rad_num   = 30'(mag) * 30'(i_point_index);
        o_item.turn_prod = 24'(i_turn_count) * 24'(i_point_index);
        o_item.phase     = i_phase_offset;
    end

endmodule

/* rtl/spg_queue.sv */
// ----------------------------------------------------------------------------
// spg_queue
// short word queue between front and back end
// ----------------------------------------------------------------------------
module spg_queue
    import spg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

/* rtl/spg_back.sv */
// ----------------------------------------------------------------------------
// spg_back
// pipelined dividers, prep register, cordic rotator, quadrant fold and output register
// ----------------------------------------------------------------------------
module spg_back
    import spg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int PHASE_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_point_total,
    input  logic [13:0]        i_outer_radius,
    input  logic [13:0]        i_center_col,
    input  logic [13:0]        i_center_row,
    input  logic               i_empty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_coord_x,
    output logic signed [15:0] o_coord_y,
    output logic               o_index_beyond,
    output logic               o_strip_end
);

    localparam int DS = 8 + PHASE_BITS;
    localparam int NS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    logic en;
    assign en    = !o_valid || !i_stall;
    assign o_pop = en && !i_empty;

    // divider pipeline, index 0 is the queue head
    logic                  d_v    [0:DS];
    logic                  d_bey  [0:DS];
    logic                  d_fin  [0:DS];
    logic                  d_sgn  [0:DS];
    logic [15:0]           d_rrem [0:DS];
    logic [13:0]           d_rnum [0:DS];
    logic [13:0]           d_rq   [0:DS];
    logic [15:0]           d_trem [0:DS];
    logic [7:0]            d_tnum [0:DS];
    logic [PHASE_BITS-1:0] d_tq   [0:DS];
    logic [15:0]           d_ph   [0:DS];

    assign d_v[0]    = o_pop;
    assign d_bey[0]  = i_item.beyond;
    assign d_fin[0]  = i_item.fin;
    assign d_sgn[0]  = i_item.sgn;
    assign d_rrem[0] = i_item.rad_num[29:14];
    assign d_rnum[0] = i_item.rad_num[13:0];
    assign d_rq[0]   = '0;
    assign d_trem[0] = i_item.turn_prod[23:8];
    assign d_tnum[0] = i_item.turn_prod[7:0];
    assign d_tq[0]   = '0;
    assign d_ph[0]   = i_item.phase;

    for (genvar s = 0; s < DS; s++) begin : g_div
        logic [16:0] rs, ts;
        assign rs = div_step(d_rrem[s], d_rnum[s][13], i_point_total);
        assign ts = div_step(d_trem[s], d_tnum[s][7], i_point_total);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                d_v[s+1] <= 1'b0;
            end else if (en) begin
                d_v[s+1] <= d_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                d_bey[s+1]  <= d_bey[s];
                d_fin[s+1]  <= d_fin[s];
                d_sgn[s+1]  <= d_sgn[s];
                d_ph[s+1]   <= d_ph[s];
                d_trem[s+1] <= ts[15:0];
                d_tnum[s+1] <= {d_tnum[s][6:0], 1'b0};
                d_tq[s+1]   <= {d_tq[s][PHASE_BITS-2:0], ts[16]};
                if (s < RAD_STEPS) begin
                    d_rrem[s+1] <= rs[15:0];
                    d_rnum[s+1] <= {d_rnum[s][12:0], 1'b0};
                    d_rq[s+1]   <= {d_rq[s][12:0], rs[16]};
                end else begin
                    d_rrem[s+1] <= d_rrem[s];
                    d_rnum[s+1] <= d_rnum[s];
                    d_rq[s+1]   <= d_rq[s];
                end
            end
        end
    end

    // radius, angle and scaled start vector
    logic signed [15:0]        radius;
    logic [PHASE_BITS+15:0]    ph_ext;
    logic [PHASE_BITS-1:0]     ang;
    logic [31:0]               a32;
    logic signed [47:0]        prod;

    always_comb begin
        radius = d_sgn[DS] ? (signed'({2'b00, i_outer_radius}) + signed'({2'b00, d_rq[DS]}))
                           : (signed'({2'b00, i_outer_radius}) - signed'({2'b00, d_rq[DS]}));
        ph_ext = {d_ph[DS], PHASE_BITS'(0)};
        ang    = d_tq[DS] + ph_ext[PHASE_BITS+15:16];
        a32    = {ang, (32-PHASE_BITS)'(0)};
        prod   = 48'(radius) * 48'(CORDIC_GAIN);
    end

    logic               r_p_v, r_p_bey, r_p_fin;
    logic [1:0]         r_p_quad;
    logic signed [31:0] r_p_x0, r_p_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= d_v[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_bey  <= d_bey[DS];
            r_p_fin  <= d_fin[DS];
            r_p_quad <= a32[31:30];
            r_p_z    <= signed'({2'b00, a32[29:0]});
            r_p_x0   <= prod[47:16];
        end
    end

    // cordic rotator
    logic               c_v    [0:NS];
    logic               c_bey  [0:NS];
    logic               c_fin  [0:NS];
    logic [1:0]         c_quad [0:NS];
    logic signed [31:0] c_x    [0:NS];
    logic signed [31:0] c_y    [0:NS];
    logic signed [31:0] c_z    [0:NS];

    assign c_v[0]    = r_p_v;
    assign c_bey[0]  = r_p_bey;
    assign c_fin[0]  = r_p_fin;
    assign c_quad[0] = r_p_quad;
    assign c_x[0]    = r_p_x0;
    assign c_y[0]    = '0;
    assign c_z[0]    = r_p_z;

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        logic signed [31:0] xs, ys, at;
        assign xs = c_x[k] >>> k;
        assign ys = c_y[k] >>> k;
        assign at = signed'(atan_turn(5'(k)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                c_v[k+1] <= 1'b0;
            end else if (en) begin
                c_v[k+1] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                c_bey[k+1]  <= c_bey[k];
                c_fin[k+1]  <= c_fin[k];
                c_quad[k+1] <= c_quad[k];
                if (!c_z[k][31]) begin
                    c_x[k+1] <= c_x[k] - ys;
                    c_y[k+1] <= c_y[k] + xs;
                    c_z[k+1] <= c_z[k] - at;
                end else begin
                    c_x[k+1] <= c_x[k] + ys;
                    c_y[k+1] <= c_y[k] - xs;
                    c_z[k+1] <= c_z[k] + at;
                end
            end
        end
    end

    // quadrant fold, rounding, center offset, saturation and zeroing of beyond words
    logic signed [31:0] rx, ry, rxs, rys;
    logic signed [18:0] sx, sy;
    logic signed [15:0] n_x, n_y;

    always_comb begin
        case (c_quad[NS])
            2'd1:    begin rx = -c_y[NS]; ry = c_x[NS];  end
            2'd2:    begin rx = -c_x[NS]; ry = -c_y[NS]; end
            2'd3:    begin rx = c_y[NS];  ry = -c_x[NS]; end
            default: begin rx = c_x[NS];  ry = c_y[NS];  end
        endcase
        rxs = (rx + 32'sd8192) >>> 14;
        rys = (ry + 32'sd8192) >>> 14;
        sx  = signed'({5'b0, i_center_col}) + rxs[18:0];
        sy  = signed'({5'b0, i_center_row}) + rys[18:0];
        if (sx > 19'sd32767) begin
            n_x = 16'sh7fff;
        end else if (sx < -19'sd32768) begin
            n_x = -16'sh8000;
        end else begin
            n_x = sx[15:0];
        end
        if (sy > 19'sd32767) begin
            n_y = 16'sh7fff;
        end else if (sy < -19'sd32768) begin
            n_y = -16'sh8000;
        end else begin
            n_y = sy[15:0];
        end
        if (c_bey[NS]) begin
            n_x = '0;
            n_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= c_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_coord_x      <= n_x;
            o_coord_y      <= n_y;
            o_index_beyond <= c_bey[NS];
            o_strip_end    <= c_fin[NS];
        end
    end

endmodule

/* rtl/spiral_point_generator.sv */
// ----------------------------------------------------------------------------
// spiral_point_generator
// points of an archimedean spiral running from outer to inner radius, from index and phase
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry one word of point index, phase and
// strip-end flag; output channel: o_valid / i_stall carry x, y, index_beyond
// and strip_end. one result word per input word, in order.
// throughput: one word per cycle while i_stall is low. the path from accept to
// o_valid runs through the queue, the pipelined dividers (one quotient bit per
// stage), the prep register, one cordic stage per micro-rotation (capped at 24)
// and the output register.
// a four-word queue parts the front from the back pipeline; o_stall rises
// only when that queue is full, so i_stall backs up the pipeline and then the
// queue before the input side sees it.
// reset empties the queue and the pipeline and loads the register defaults.
// registers are written through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata; the user
// writes them only while no word is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module spiral_point_generator
    import spg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int PHASE_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_point_index,
    input  logic [15:0]        i_phase_offset,
    input  logic               i_final_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_coord_x,
    output logic signed [15:0] o_coord_y,
    output logic               o_index_beyond,
    output logic               o_strip_end
);

    logic [15:0] r_point_total;
    logic [7:0]  r_turn_count;
    logic [13:0] r_outer_radius, r_inner_radius, r_center_col, r_center_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_total  <= 16'd3000;
            r_turn_count   <= 8'd30;
            r_outer_radius <= 14'd4000;
            r_inner_radius <= 14'd160;
            r_center_col   <= 14'd4800;
            r_center_row   <= 14'd4800;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_POINT_TOTAL:  r_point_total  <= i_cfg_wdata;
                REG_TURN_COUNT:   r_turn_count   <= i_cfg_wdata[7:0];
                REG_OUTER_RADIUS: r_outer_radius <= i_cfg_wdata[13:0];
                REG_INNER_RADIUS: r_inner_radius <= i_cfg_wdata[13:0];
                REG_CENTER_COL:   r_center_col   <= i_cfg_wdata[13:0];
                REG_CENTER_ROW:   r_center_row   <= i_cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    t_item front_item, head_item;
    logic  q_full, q_empty, q_pop;

    spg_front u_front (
        .i_point_total  (r_point_total),
        .i_turn_count   (r_turn_count),
        .i_outer_radius (r_outer_radius),
        .i_inner_radius (r_inner_radius),
        .i_point_index  (i_point_index),
        .i_phase_offset (i_phase_offset),
        .i_final_point  (i_final_point),
        .o_item         (front_item)
    );

    assign o_stall = q_full;

    spg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    spg_back #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .PHASE_BITS   (PHASE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_point_total  (r_point_total),
        .i_outer_radius (r_outer_radius),
        .i_center_col   (r_center_col),
        .i_center_row   (r_center_row),
        .i_empty        (q_empty),
        .i_item         (head_item),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_coord_x      (o_coord_x),
        .o_coord_y      (o_coord_y),
        .o_index_beyond (o_index_beyond),
        .o_strip_end    (o_strip_end)
    );

endmodule

/* rtl/spg_checker.sv */
// ----------------------------------------------------------------------------
// spg_checker
// port-level checks of the spiral generator
// ----------------------------------------------------------------------------
module spg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_coord_x,
    input logic signed [15:0] o_coord_y,
    input logic               o_index_beyond,
    input logic               o_strip_end
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_coord_x) && $stable(o_coord_y)
            && $stable(o_index_beyond) && $stable(o_strip_end))
        else $error("output word changed under stall");

    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_beyond |-> o_coord_x == 16'sd0 && o_coord_y == 16'sd0)
        else $error("beyond word has nonzero coordinates");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind spiral_point_generator spg_checker u_spg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_coord_x      (o_coord_x),
    .o_coord_y      (o_coord_y),
    .o_index_beyond (o_index_beyond),
    .o_strip_end    (o_strip_end)
);
